### src/dcp_pkg.sv
package dcp_pkg;

    typedef enum logic [4:0] {
        PH_SEP  = 5'b00001,
        PH_NAME = 5'b00010,
        PH_EQ   = 5'b00100,
        PH_BVAL = 5'b01000,
        PH_QVAL = 5'b10000
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_NONE      = 3'd0;
    localparam kind_t KIND_REALM     = 3'd1;
    localparam kind_t KIND_OPAQUE    = 3'd4;
    localparam kind_t KIND_STALE     = 3'd5;
    localparam kind_t KIND_ALGORITHM = 3'd6;
    localparam kind_t KIND_QOP       = 3'd7;

    localparam logic [2:0] ALG_MD5  = 3'b001;
    localparam logic [2:0] ALG_SESS = 3'b010;
    localparam logic [2:0] ALG_SPEC = 3'b100;

    localparam logic [1:0] QOP_AUTH     = 2'b01;
    localparam logic [1:0] QOP_AUTH_INT = 2'b10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int NUM_NAMES = 7;

    // Keywords are held left-justified in nine characters, padded with spaces.
    localparam logic [71:0] NAME_STR [NUM_NAMES] = '{
        "realm    ", "domain   ", "nonce    ", "opaque   ",
        "stale    ", "algorithm", "qop      "
    };
    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
        4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd9, 4'd3
    };

    localparam logic [71:0] ALG_STR [2] = '{"md5      ", "md5-sess "};
    localparam logic [3:0]  ALG_LEN [2] = '{4'd3, 4'd8};
    localparam logic [71:0] TOK_STR [2] = '{"auth     ", "auth-int "};
    localparam logic [3:0]  TOK_LEN [2] = '{4'd4, 4'd8};
    localparam logic [71:0] TRUE_STR    = "true     ";
    localparam logic [3:0]  TRUE_LEN    = 4'd4;

    localparam logic [3:0] LEN_MAX = 4'd15;

    typedef struct packed {
        logic       value_valid;
        logic       value_start;
        logic [1:0] value_field;
        logic [7:0] value_byte;
        logic       done_res;
        logic       parse_status;
        logic       stale_flag;
        logic       alg_given;
        logic       alg_plain;
        logic       alg_session;
        logic       qop_basic;
        logic       qop_integrity;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [3:0] sat_inc(input logic [3:0] v);
        return (v < LEN_MAX) ? v + 4'd1 : v;
    endfunction

    function automatic logic [7:0] kw_char(input logic [71:0] s, input logic [3:0] p);
        logic [7:0] r;
        unique case (p)
            4'd0:    r = s[71:64];
            4'd1:    r = s[63:56];
            4'd2:    r = s[55:48];
            4'd3:    r = s[47:40];
            4'd4:    r = s[39:32];
            4'd5:    r = s[31:24];
            4'd6:    r = s[23:16];
            4'd7:    r = s[15:8];
            4'd8:    r = s[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] finish_token(input logic [1:0] qop,
                                                input logic [3:0] len,
                                                input logic [1:0] mask);
        logic [1:0] r;
        r = qop;
        if (len == TOK_LEN[0] && mask[0]) begin
            r = qop | QOP_AUTH;
        end else if (len == TOK_LEN[1] && mask[1]) begin
            r = qop | QOP_AUTH_INT;
        end
        return r;
    endfunction

endpackage

### src/digest_challenge_parser_unit.sv
// Digest challenge parser.
// The input channel (in_valid, in_stall, text_byte, end_of_text) takes the
// challenge text one byte per word, with the scheme prefix already removed,
// and a final word with end_of_text set that stands for the terminating NUL.
// The output channel (out_valid, out_stall and the result fields) carries
// value bytes of realm, domain, nonce and opaque, each tagged with its field
// and with value_start on the first word of a value, and one summary word
// with done_res set for the end word, holding the status, stale, algorithm
// and qop flags. Words that produce no result give nothing on the output.
// One input word is accepted every clock cycle unless stalled; its result,
// if any, is presented from the output register in the next cycle. The
// single output register decides the rate: while it holds a word that the
// receiver stalls, in_stall is raised and no input is taken. Reset clears
// the parser state to its start condition and empties the output register;
// after the end word the parser returns to the same start condition.
module digest_challenge_parser_unit
    import dcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       value_valid,
    output logic       value_start,
    output logic [1:0] value_field,
    output logic [7:0] value_byte,
    output logic       done_res,
    output logic       parse_status,
    output logic       stale_flag,
    output logic       alg_given,
    output logic       alg_plain,
    output logic       alg_session,
    output logic       qop_basic,
    output logic       qop_integrity
);

    phase_t     phase_reg, phase_next;
    logic [3:0] name_length_reg, name_length_next;
    logic [6:0] name_mask_reg, name_mask_next;
    kind_t      value_kind_reg, value_kind_next;
    logic [3:0] value_length_reg, value_length_next;
    logic [2:0] value_mask_reg, value_mask_next;
    logic [3:0] token_length_reg, token_length_next;
    logic [1:0] token_mask_reg, token_mask_next;
    logic       stale_reg, stale_next;
    logic [2:0] algorithm_reg, algorithm_next;
    logic [1:0] qop_reg, qop_next;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg, result_next;

    logic       in_fire;
    logic       res_load;
    logic [7:0] lc;
    logic       sp;
    logic       is_sep;
    logic       is_name_end;
    logic       begin_val;
    logic       user_kind;

    logic [3:0] eff_nl;
    logic [6:0] eff_nm;
    logic [6:0] upd_nm;
    kind_t      fin_kind;
    logic       found;

    logic [3:0] eff_vl;
    logic [2:0] eff_vm;
    logic [3:0] eff_tl;
    logic [1:0] eff_tm;

    logic       fin_stale;
    logic [2:0] fin_alg;
    logic [1:0] fin_qop;

    logic [2:0] vc_vm;
    logic [3:0] vc_tl;
    logic [1:0] vc_tm;
    logic [1:0] vc_qop;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    assign lc          = to_lower(text_byte);
    assign sp          = is_space(text_byte);
    assign is_sep      = sp | (text_byte == CH_COMMA);
    assign is_name_end = sp | (text_byte == CH_EQUAL);
    assign begin_val   = (phase_reg == PH_EQ) & ~is_name_end;
    assign user_kind   = (value_kind_reg >= KIND_REALM) & (value_kind_reg <= KIND_OPAQUE);

    // Name matching; a separator phase starts a fresh name with this byte.
    assign eff_nl = (phase_reg == PH_SEP) ? 4'd0 : name_length_reg;
    assign eff_nm = (phase_reg == PH_SEP) ? 7'h7f : name_mask_reg;

    always_comb
    begin
        upd_nm = eff_nm;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            if (eff_nl >= NAME_LEN[i] || lc != kw_char(NAME_STR[i], eff_nl))
            begin
                upd_nm[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        fin_kind = KIND_NONE;
        found    = 1'b0;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            if (!found && eff_nm[i] && eff_nl == NAME_LEN[i])
            begin
                fin_kind = kind_t'(i + 1);
                found    = 1'b1;
            end
        end
    end

    // A value that begins on this byte sees freshly cleared match state.
    assign eff_vl = begin_val ? 4'd0   : value_length_reg;
    assign eff_vm = begin_val ? 3'b111 : value_mask_reg;
    assign eff_tl = begin_val ? 4'd0   : token_length_reg;
    assign eff_tm = begin_val ? 2'b11  : token_mask_reg;

    always_comb
    begin
        fin_stale = stale_reg;
        fin_alg   = algorithm_reg;
        fin_qop   = qop_reg;
        if (value_kind_reg == KIND_STALE)
        begin
            fin_stale = (eff_vl >= TRUE_LEN) & eff_vm[0];
        end
        else if (value_kind_reg == KIND_ALGORITHM)
        begin
            fin_alg = ALG_SPEC;
            if (eff_vl == ALG_LEN[0] && eff_vm[1])
            begin
                fin_alg = ALG_SPEC | ALG_MD5;
            end
            else if (eff_vl == ALG_LEN[1] && eff_vm[2])
            begin
                fin_alg = ALG_SPEC | ALG_SESS;
            end
        end
        else if (value_kind_reg == KIND_QOP && eff_tl != 4'd0)
        begin
            fin_qop = finish_token(qop_reg, eff_tl, eff_tm);
        end
    end

    always_comb
    begin
        vc_vm  = eff_vm;
        vc_tl  = eff_tl;
        vc_tm  = eff_tm;
        vc_qop = qop_reg;
        if (value_kind_reg == KIND_STALE)
        begin
            if (eff_vl < TRUE_LEN && lc != kw_char(TRUE_STR, eff_vl))
            begin
                vc_vm[0] = 1'b0;
            end
        end
        else if (value_kind_reg == KIND_ALGORITHM)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (eff_vl >= ALG_LEN[i] || lc != kw_char(ALG_STR[i], eff_vl))
                begin
                    vc_vm[i + 1] = 1'b0;
                end
            end
        end
        else if (value_kind_reg == KIND_QOP)
        begin
            if (is_sep)
            begin
                if (eff_tl != 4'd0)
                begin
                    vc_qop = finish_token(qop_reg, eff_tl, eff_tm);
                    vc_tl  = 4'd0;
                    vc_tm  = 2'b11;
                end
            end
            else
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (eff_tl >= TOK_LEN[i] || lc != kw_char(TOK_STR[i], eff_tl))
                    begin
                        vc_tm[i] = 1'b0;
                    end
                end
                vc_tl = sat_inc(eff_tl);
            end
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        name_length_next  = name_length_reg;
        name_mask_next    = name_mask_reg;
        value_kind_next   = value_kind_reg;
        value_length_next = value_length_reg;
        value_mask_next   = value_mask_reg;
        token_length_next = token_length_reg;
        token_mask_next   = token_mask_reg;
        stale_next        = stale_reg;
        algorithm_next    = algorithm_reg;
        qop_next          = qop_reg;
        res_load          = 1'b0;
        result_next       = '0;

        if (in_fire)
        begin
            if (end_of_text)
            begin
                res_load             = 1'b1;
                result_next.done_res = 1'b1;
                result_next.parse_status = (phase_reg == PH_NAME) ||
                                           (phase_reg == PH_EQ) ||
                                           (phase_reg == PH_QVAL);
                if (phase_reg == PH_BVAL)
                begin
                    result_next.stale_flag    = fin_stale;
                    result_next.alg_given     = fin_alg[2];
                    result_next.alg_plain     = fin_alg[0];
                    result_next.alg_session   = fin_alg[1];
                    result_next.qop_basic     = fin_qop[0];
                    result_next.qop_integrity = fin_qop[1];
                end
                else
                begin
                    result_next.stale_flag    = stale_reg;
                    result_next.alg_given     = algorithm_reg[2];
                    result_next.alg_plain     = algorithm_reg[0];
                    result_next.alg_session   = algorithm_reg[1];
                    result_next.qop_basic     = qop_reg[0];
                    result_next.qop_integrity = qop_reg[1];
                end
                phase_next        = PH_SEP;
                name_length_next  = 4'd0;
                name_mask_next    = 7'h7f;
                value_kind_next   = KIND_NONE;
                value_length_next = 4'd0;
                value_mask_next   = 3'b111;
                token_length_next = 4'd0;
                token_mask_next   = 2'b11;
                stale_next        = 1'b0;
                algorithm_next    = ALG_MD5;
                qop_next          = 2'b00;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SEP, PH_NAME:
                    begin
                        if (phase_reg == PH_SEP && is_sep)
                        begin
                            phase_next = PH_SEP;
                        end
                        else if (is_name_end)
                        begin
                            name_length_next = eff_nl;
                            name_mask_next   = eff_nm;
                            value_kind_next  = fin_kind;
                            phase_next       = PH_EQ;
                        end
                        else
                        begin
                            name_length_next = sat_inc(eff_nl);
                            name_mask_next   = upd_nm;
                            phase_next       = PH_NAME;
                        end
                    end
                    PH_EQ:
                    begin
                        if (!is_name_end)
                        begin
                            value_length_next = eff_vl;
                            value_mask_next   = eff_vm;
                            token_length_next = eff_tl;
                            token_mask_next   = eff_tm;
                            if (text_byte == CH_QUOTE || text_byte == CH_COMMA)
                            begin
                                if (text_byte == CH_QUOTE)
                                begin
                                    phase_next = PH_QVAL;
                                end
                                else
                                begin
                                    stale_next     = fin_stale;
                                    algorithm_next = fin_alg;
                                    qop_next       = fin_qop;
                                    phase_next     = PH_SEP;
                                end
                                if (user_kind)
                                begin
                                    res_load                = 1'b1;
                                    result_next.value_start = 1'b1;
                                    result_next.value_field = 2'(value_kind_reg - KIND_REALM);
                                end
                            end
                            else
                            begin
                                phase_next        = PH_BVAL;
                                value_length_next = sat_inc(eff_vl);
                                value_mask_next   = vc_vm;
                                token_length_next = vc_tl;
                                token_mask_next   = vc_tm;
                                qop_next          = vc_qop;
                                if (user_kind)
                                begin
                                    res_load                = 1'b1;
                                    result_next.value_valid = 1'b1;
                                    result_next.value_start = 1'b1;
                                    result_next.value_field = 2'(value_kind_reg - KIND_REALM);
                                    result_next.value_byte  = text_byte;
                                end
                            end
                        end
                    end
                    PH_BVAL, PH_QVAL:
                    begin
                        if ((phase_reg == PH_BVAL && is_sep) ||
                            (phase_reg == PH_QVAL && text_byte == CH_QUOTE))
                        begin
                            stale_next     = fin_stale;
                            algorithm_next = fin_alg;
                            qop_next       = fin_qop;
                            if (value_kind_reg == KIND_QOP && eff_tl != 4'd0)
                            begin
                                token_length_next = 4'd0;
                                token_mask_next   = 2'b11;
                            end
                            phase_next = PH_SEP;
                        end
                        else
                        begin
                            value_length_next = sat_inc(eff_vl);
                            value_mask_next   = vc_vm;
                            token_length_next = vc_tl;
                            token_mask_next   = vc_tm;
                            qop_next          = vc_qop;
                            if (user_kind)
                            begin
                                res_load                = 1'b1;
                                result_next.value_valid = 1'b1;
                                result_next.value_field = 2'(value_kind_reg - KIND_REALM);
                                result_next.value_byte  = text_byte;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SEP;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (in_fire && res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEP;
            name_length_reg  <= 4'd0;
            name_mask_reg    <= 7'h7f;
            value_kind_reg   <= KIND_NONE;
            value_length_reg <= 4'd0;
            value_mask_reg   <= 3'b111;
            token_length_reg <= 4'd0;
            token_mask_reg   <= 2'b11;
            stale_reg        <= 1'b0;
            algorithm_reg    <= ALG_MD5;
            qop_reg          <= 2'b00;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            name_length_reg  <= name_length_next;
            name_mask_reg    <= name_mask_next;
            value_kind_reg   <= value_kind_next;
            value_length_reg <= value_length_next;
            value_mask_reg   <= value_mask_next;
            token_length_reg <= token_length_next;
            token_mask_reg   <= token_mask_next;
            stale_reg        <= stale_next;
            algorithm_reg    <= algorithm_next;
            qop_reg          <= qop_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign value_valid   = result_reg.value_valid;
    assign value_start   = result_reg.value_start;
    assign value_field   = result_reg.value_field;
    assign value_byte    = result_reg.value_byte;
    assign done_res      = result_reg.done_res;
    assign parse_status  = result_reg.parse_status;
    assign stale_flag    = result_reg.stale_flag;
    assign alg_given     = result_reg.alg_given;
    assign alg_plain     = result_reg.alg_plain;
    assign alg_session   = result_reg.alg_session;
    assign qop_basic     = result_reg.qop_basic;
    assign qop_integrity = result_reg.qop_integrity;

endmodule
